### src/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 32;
    localparam int unsigned M_USER_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_BYTE  = 2'd2;

    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd500;
    localparam logic [7:0]  START_BYTE_RESET  = 8'hae;
    localparam logic [7:0]  TOKEN_BYTE_RESET  = 8'hf0;

    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEAD   = 3'd0,
        PH_DIR    = 3'd1,
        PH_TOKEN  = 3'd2,
        PH_LEN    = 3'd3,
        PH_TYPE   = 3'd4,
        PH_DATA   = 3'd5,
        PH_VERIFY = 3'd6
    } phase_t;

    typedef struct packed {
        logic [15:0] gap_timeout;
        logic [7:0]  start_byte;
        logic [7:0]  token_byte;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_dir;
        logic [7:0]  frame_type;
        logic [7:0]  frame_len;
    } result_t;

endpackage

`default_nettype wire

### src/framed_packet_receive_parser.sv
// A result appears on the master side in the cycle after the byte transaction that causes it.
// Throughput: one input transaction per cycle while the result register is empty or being taken.
// Tick transactions and header bytes produce no result.
// Reset (aresetn low, synchronous) returns the parser to hunting for the start byte,
// clears the tick counter and held frame fields, and restores the register defaults.
`default_nettype none

module framed_packet_receive_parser
    import fpr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // rx_byte
    input  wire logic                  s_tuser,   // action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // payload_byte [7:0], frame_dir [9:8], frame_type [17:10], frame_len [25:18], zero fill
    output logic [M_DATA_W-1:0]        m_tdata,
    output logic [M_USER_W-1:0]        m_tuser    // kind
);

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg;
    logic    s_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_timeout <= GAP_TIMEOUT_RESET;
            cfg_reg.start_byte  <= START_BYTE_RESET;
            cfg_reg.token_byte  <= TOKEN_BYTE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAP_TIMEOUT: cfg_reg.gap_timeout <= cfg_wdata;
                REG_START_BYTE:  cfg_reg.start_byte  <= cfg_wdata[7:0];
                REG_TOKEN_BYTE:  cfg_reg.token_byte  <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !out_reg.valid || m_tready;
    assign s_accept = s_tvalid && s_tready;

    fpr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .action  (s_tuser),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (s_tready) begin
            out_reg.valid <= result.valid;
        end
        if (s_accept && result.valid) begin
            out_reg.kind         <= result.kind;
            out_reg.payload_byte <= result.payload_byte;
            out_reg.frame_dir    <= result.frame_dir;
            out_reg.frame_type   <= result.frame_type;
            out_reg.frame_len    <= result.frame_len;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.frame_len, out_reg.frame_type,
                       out_reg.frame_dir, out_reg.payload_byte};

    a_tick_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == ACTION_TICK) |=> !m_tvalid)
        else $error("tick transaction produced a result");

    a_payload_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.kind == KIND_PAYLOAD) |->
        (out_reg.frame_dir == 2'd0 && out_reg.frame_type == 8'd0 && out_reg.frame_len == 8'd0))
        else $error("payload result carries frame fields");

    a_verdict_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.kind != KIND_PAYLOAD) |->
        ((out_reg.frame_dir == DIR_DOWN || out_reg.frame_dir == DIR_UP)
         && out_reg.payload_byte == 8'd0))
        else $error("verdict result with bad direction or payload");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.kind == KIND_PAYLOAD || out_reg.kind == KIND_GOOD
                      || out_reg.kind == KIND_BAD))
        else $error("result with unused kind code");

endmodule

`default_nettype wire

### src/fpr_parser.sv
`default_nettype none

module fpr_parser
    import fpr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic       action,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output result_t         result
);

    phase_t      phase_reg,     phase_next;
    logic [1:0]  held_dir_reg,  held_dir_next;
    logic [7:0]  held_len_reg,  held_len_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [7:0]  count_reg,     count_next;
    logic [7:0]  sum_reg,       sum_next;
    logic [15:0] quiet_reg,     quiet_next;

    phase_t      phase_eff;
    logic [7:0]  count_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEAD;
            held_dir_reg  <= '0;
            held_len_reg  <= '0;
            held_type_reg <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            quiet_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            held_dir_reg  <= held_dir_next;
            held_len_reg  <= held_len_next;
            held_type_reg <= held_type_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            quiet_reg     <= quiet_next;
        end
    end

    assign count_inc = count_reg + 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        held_dir_next  = held_dir_reg;
        held_len_next  = held_len_reg;
        held_type_next = held_type_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        quiet_next     = quiet_reg;
        phase_eff      = phase_reg;
        result         = '0;

        if (accept) begin
            if (action == ACTION_TICK) begin
                if (quiet_reg != '1) begin
                    quiet_next = quiet_reg + 16'd1;
                end
            end else begin
                // A long enough silence abandons any frame in progress.
                if (quiet_reg >= cfg.gap_timeout) begin
                    phase_eff = PH_HEAD;
                end
                quiet_next = '0;
                phase_next = phase_eff;
                case (phase_eff)
                    PH_HEAD: begin
                        if (rx_byte == cfg.start_byte) begin
                            phase_next = PH_DIR;
                        end
                    end
                    PH_DIR: begin
                        if (rx_byte == {6'd0, DIR_DOWN} || rx_byte == {6'd0, DIR_UP}) begin
                            held_dir_next = rx_byte[1:0];
                            phase_next    = PH_TOKEN;
                        end else begin
                            phase_next = PH_HEAD;
                        end
                    end
                    PH_TOKEN: begin
                        phase_next = (rx_byte == cfg.token_byte) ? PH_LEN : PH_HEAD;
                    end
                    PH_LEN: begin
                        held_len_next = rx_byte;
                        phase_next    = PH_TYPE;
                    end
                    PH_TYPE: begin
                        held_type_next = rx_byte;
                        count_next     = '0;
                        sum_next       = rx_byte;
                        phase_next     = (held_len_reg > 8'd1) ? PH_DATA : PH_VERIFY;
                    end
                    PH_DATA: begin
                        result.valid        = 1'b1;
                        result.kind         = KIND_PAYLOAD;
                        result.payload_byte = rx_byte;
                        sum_next            = sum_reg + rx_byte;
                        count_next          = count_inc;
                        if (count_inc >= held_len_reg - 8'd1) begin
                            phase_next = PH_VERIFY;
                        end
                    end
                    PH_VERIFY: begin
                        result.valid      = 1'b1;
                        result.kind       = (rx_byte == sum_reg) ? KIND_GOOD : KIND_BAD;
                        result.frame_dir  = held_dir_reg;
                        result.frame_type = held_type_reg;
                        result.frame_len  = held_len_reg;
                        phase_next        = PH_HEAD;
                    end
                    default: begin
                        phase_next = PH_HEAD;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### dv/framed_packet_receive_parser_tb.sv
module framed_packet_receive_parser_tb;
    import fpr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [1:0] frame_dir;
        logic [7:0] frame_type;
        logic [7:0] frame_len;
    } rx_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_QUARTER,
        READY_MOSTLY
    } ready_style_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;

    framed_packet_receive_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Register copies and parser state, used to work out each result.
    logic [15:0] gap_limit   = GAP_TIMEOUT_RESET;
    logic [7:0]  start_code  = START_BYTE_RESET;
    logic [7:0]  token_code  = TOKEN_BYTE_RESET;
    phase_t      frame_phase = PH_HEAD;
    logic [1:0]  held_dir    = '0;
    logic [7:0]  held_len    = '0;
    logic [7:0]  held_type   = '0;
    logic [7:0]  payload_count = '0;
    logic [7:0]  running_sum = '0;
    logic [15:0] quiet_ticks = '0;

    rx_result_t rx_results_due[$];

    int mismatches      = 0;
    int items_sent      = 0;
    int ticks_sent      = 0;
    int payloads_seen   = 0;
    int verdicts_good   = 0;
    int verdicts_bad    = 0;
    int burst_left      = 0;
    int hold_off_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("%0t: timeout, %0d results still awaited", $time, rx_results_due.size());
        $display("framed_packet_receive_parser_tb NOT OK");
        $finish;
    end

    function automatic bit parse_rx_symbol(input logic act, input logic [7:0] b,
                                           output rx_result_t res);
        res = '0;
        if (act == ACTION_TICK) begin
            if (quiet_ticks != 16'hFFFF) quiet_ticks++;
            return 1'b0;
        end
        if (quiet_ticks >= gap_limit) frame_phase = PH_HEAD;
        quiet_ticks = '0;
        case (frame_phase)
            PH_HEAD: begin
                if (b == start_code) frame_phase = PH_DIR;
            end
            PH_DIR: begin
                if (b == DIR_DOWN || b == DIR_UP) begin
                    held_dir = b[1:0];
                    frame_phase = PH_TOKEN;
                end else begin
                    frame_phase = PH_HEAD;
                end
            end
            PH_TOKEN: begin
                frame_phase = (b == token_code) ? PH_LEN : PH_HEAD;
            end
            PH_LEN: begin
                held_len = b;
                frame_phase = PH_TYPE;
            end
            PH_TYPE: begin
                held_type = b;
                payload_count = '0;
                running_sum = b;
                frame_phase = (held_len > 8'd1) ? PH_DATA : PH_VERIFY;
            end
            PH_DATA: begin
                res.kind = KIND_PAYLOAD;
                res.payload_byte = b;
                running_sum = running_sum + b;
                payload_count = payload_count + 8'd1;
                if (payload_count >= held_len - 8'd1) frame_phase = PH_VERIFY;
                return 1'b1;
            end
            PH_VERIFY: begin
                res.kind = (b == running_sum) ? KIND_GOOD : KIND_BAD;
                res.frame_dir = held_dir;
                res.frame_type = held_type;
                res.frame_len = held_len;
                frame_phase = PH_HEAD;
                return 1'b1;
            end
            default: begin
                frame_phase = PH_HEAD;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic send_item(input logic act, input logic [7:0] b);
        rx_result_t res;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        burst_left--;
        items_sent++;
        if (act == ACTION_TICK) ticks_sent++;
        if (parse_rx_symbol(act, b, res)) rx_results_due.push_back(res);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(ACTION_TICK, 8'($urandom));
    endtask

    // A byte, sometimes preceded by a run of ticks that may or may not end the frame.
    task automatic send_rx_byte(input logic [7:0] b);
        if ($urandom_range(0, 7) == 0) begin
            if (gap_limit <= 16 && $urandom_range(0, 3) == 0)
                send_ticks($urandom_range(gap_limit, gap_limit + 2));
            else if (gap_limit > 1)
                send_ticks($urandom_range(1, (gap_limit > 4) ? 3 : gap_limit - 1));
        end
        send_item(ACTION_BYTE, b);
    endtask

    task automatic send_frame(input logic [7:0] dir_code, input logic [7:0] len,
                              input bit corrupt);
        logic [7:0] type_code;
        logic [7:0] sum;
        logic [7:0] pb;
        type_code = 8'($urandom);
        sum = type_code;
        send_rx_byte(start_code);
        send_rx_byte(dir_code);
        send_rx_byte(token_code);
        send_rx_byte(len);
        send_rx_byte(type_code);
        for (int i = 1; i < len; i++) begin
            pb = 8'($urandom);
            sum = sum + pb;
            send_rx_byte(pb);
        end
        send_rx_byte(corrupt ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (rx_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] gap, input logic [7:0] start,
                             input logic [7:0] token);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAP_TIMEOUT;
        cfg_wdata <= gap;
        @(posedge aclk);
        cfg_index <= REG_START_BYTE;
        cfg_wdata <= {8'($urandom), start};
        @(posedge aclk);
        cfg_index <= REG_TOKEN_BYTE;
        cfg_wdata <= {8'($urandom), token};
        @(posedge aclk);
        cfg_index <= REG_UNMAPPED;
        cfg_wdata <= 16'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
        gap_limit  = gap;
        start_code = start;
        token_code = token;
    endtask

    task automatic test_directed_frames();
        logic [7:0] frames [26] = '{
            8'hAE, 8'h01, 8'hF0, 8'h00, 8'hFF, 8'hFF,
            8'hAE, 8'h02, 8'hF0, 8'h01, 8'h00, 8'h01,
            8'hAE, 8'h01, 8'hF0, 8'h03, 8'h80, 8'h00, 8'hFF, 8'h7F,
            8'hAE, 8'hAE, 8'h01,
            8'hAE, 8'h02, 8'h0F
        };
        foreach (frames[i]) send_item(ACTION_BYTE, frames[i]);
        send_item(ACTION_TICK, 8'hFF);
    endtask

    task automatic test_gap_timeout();
        logic [7:0] opening [6] = '{8'hAE, 8'h01, 8'hF0, 8'h00, 8'h00, 8'h00};
        logic [8:0] steps [16] = '{
            {ACTION_BYTE, 8'h55}, {ACTION_BYTE, 8'h02}, {ACTION_BYTE, 8'hAA},
            {ACTION_BYTE, 8'h02}, {ACTION_BYTE, 8'h10}, {ACTION_TICK, 8'h5A},
            {ACTION_BYTE, 8'h20}, {ACTION_TICK, 8'hA5}, {ACTION_TICK, 8'h00},
            {ACTION_BYTE, 8'h30}, {ACTION_BYTE, 8'h55}, {ACTION_BYTE, 8'h01},
            {ACTION_BYTE, 8'hAA}, {ACTION_BYTE, 8'h00}, {ACTION_BYTE, 8'hC3},
            {ACTION_BYTE, 8'hC3}
        };
        // With a zero timeout every byte restarts the hunt, so no frame gets going.
        configure(16'd0, START_BYTE_RESET, TOKEN_BYTE_RESET);
        foreach (opening[i]) send_item(ACTION_BYTE, opening[i]);
        configure(16'd2, 8'h55, 8'hAA);
        foreach (steps[i]) send_item(steps[i][8], steps[i][7:0]);
    endtask

    // A quiet spell just short of the timeout keeps the frame open; one that reaches it
    // restarts the hunt.
    task automatic test_long_quiet();
        configure(16'd100, START_BYTE_RESET, TOKEN_BYTE_RESET);
        send_item(ACTION_BYTE, START_BYTE_RESET);
        send_ticks(99);
        send_item(ACTION_BYTE, DIR_DOWN);
        send_item(ACTION_BYTE, TOKEN_BYTE_RESET);
        send_ticks(100);
        send_item(ACTION_BYTE, START_BYTE_RESET);
        send_item(ACTION_BYTE, DIR_UP);
        send_item(ACTION_BYTE, TOKEN_BYTE_RESET);
        send_item(ACTION_BYTE, 8'h02);
        send_item(ACTION_BYTE, 8'h11);
        send_item(ACTION_BYTE, 8'h22);
        send_item(ACTION_BYTE, 8'h33);
    endtask

    task automatic test_backpressure();
        settle();
        hold_off_cycles = 300;
        send_frame(DIR_UP, 8'd48, 1'b0);
        send_frame(DIR_DOWN, 8'd20, 1'b1);
        settle();
    endtask

    task automatic test_random_traffic();
        int phase_end;
        logic [7:0] len;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: configure(16'($urandom_range(2, 12)), 8'($urandom), 8'($urandom));
                1: configure(16'hFFFF, 8'hFF, 8'h00);
                2: configure(16'd1, 8'h00, 8'hFF);
                default: configure(16'($urandom_range(13, 65535)), 8'($urandom),
                                   8'($urandom));
            endcase
            phase_end = items_sent + 270;
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0: begin
                        repeat ($urandom_range(1, 6))
                            send_item($urandom_range(0, 1) ? ACTION_TICK : ACTION_BYTE,
                                      8'($urandom));
                    end
                    1: begin
                        send_rx_byte(start_code);
                        if ($urandom_range(0, 1)) begin
                            send_rx_byte(8'($urandom));
                        end else begin
                            send_rx_byte(8'($urandom_range(1, 2)));
                            send_rx_byte(8'($urandom));
                        end
                    end
                    2: begin
                        send_rx_byte(start_code);
                        send_rx_byte(8'($urandom_range(1, 2)));
                        send_rx_byte(token_code);
                        send_rx_byte(8'($urandom_range(2, 12)));
                        send_rx_byte(8'($urandom));
                        send_rx_byte(8'($urandom));
                        if (gap_limit <= 64) send_ticks(gap_limit);
                    end
                    default: begin
                        len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(13, 255))
                                                           : 8'($urandom_range(0, 12));
                        send_frame(8'($urandom_range(1, 2)), len, $urandom_range(0, 4) == 0);
                    end
                endcase
            end
        end
    endtask

    initial begin : result_sink
        ready_style_t style;
        int style_left;
        int beat;
        style = READY_ALWAYS;
        style_left = 50;
        beat = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            beat++;
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    READY_ALWAYS:  m_tready <= 1'b1;
                    READY_HALF:    m_tready <= 1'($urandom_range(0, 1));
                    READY_QUARTER: m_tready <= (beat % 4 == 0);
                    default:       m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                style_left--;
                if (style_left == 0) begin
                    style = ready_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(16, 160);
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        rx_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (rx_results_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual kind %0h data %0h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = rx_results_due.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                check_field("frame_dir", want.frame_dir, m_tdata[9:8]);
                check_field("frame_type", want.frame_type, m_tdata[17:10]);
                check_field("frame_len", want.frame_len, m_tdata[25:18]);
                check_field("zero fill", '0, m_tdata[M_DATA_W-1:26]);
                case (want.kind)
                    KIND_PAYLOAD: payloads_seen++;
                    KIND_GOOD:    verdicts_good++;
                    default:      verdicts_bad++;
                endcase
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACTION_BYTE;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_GAP_TIMEOUT;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frames();
        test_gap_timeout();
        test_long_quiet();
        test_backpressure();
        test_random_traffic();
        settle();
        $display("Sent %0d transactions (%0d ticks) under eight register settings.",
                 items_sent, ticks_sent);
        $display("Checked %0d payload bytes, %0d good and %0d bad frame verdicts.",
                 payloads_seen, verdicts_good, verdicts_bad);
        if (mismatches == 0) begin
            $display("framed_packet_receive_parser_tb OK");
        end else begin
            $display("framed_packet_receive_parser_tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
src/fpr_pkg.sv
src/fpr_parser.sv
src/framed_packet_receive_parser.sv
dv/framed_packet_receive_parser_tb.sv
